>>> hw/rtl/atpam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atlas tile pixel address mapper package
// Word types, field widths and command codes used by the mapper top module.
// ----------------------------------------------------------------------------
package atpam_pkg;

  localparam int unsigned CMD_W    = 1;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned PIX_W    = 12;
  localparam int unsigned GRID_W   = 5;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned OFFSET_W = 26;

  // Command codes carried in the cmd field of an input word.
  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_MAP  = 1'b1;

  // Four bytes per pixel means the source carries its own alpha.
  localparam logic [BPP_W-1:0] BPP_RGBA = 3'd4;

  localparam logic [GRID_W-1:0] GRID_RESET = 5'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] tile_slot;
    logic              tile_present;
    logic [DIM_W-1:0]  tile_width;
    logic [DIM_W-1:0]  tile_height;
    logic [BPP_W-1:0]  bytes_per_pixel;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
  } atpam_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  tile_index;
    logic [OFFSET_W-1:0] source_offset;
    logic                empty_tile;
    logic                alpha_from_source;
  } atpam_out_t;

endpackage

>>> hw/rtl/atlas_tile_pixel_address_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atlas tile pixel address mapper
// Maps atlas pixels to byte offsets inside their source textures, using a
// tile descriptor table that load commands fill.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_stall | atpam_in_t: load or map
//   out     | output    | out_valid/out_stall | atpam_out_t: one per map
//   cfg     | input     | cfg_valid/cfg_ready | grid_size, 5 bits
//
// One word is accepted every clock while the output side keeps up. A map
// word passes the table read, the scaling products, the border divider
// (one pipeline stage per quotient bit, QW being its quotient width), the
// offset registers and the output register. A load word writes the table at
// the edge that accepts it and gives no result.
// Reset clears the per-slot valid bits at once, so there is no
// clearing sweep; every slot reads as absent until loaded.
// When the output stalls, one more result is caught in a skid register,
// after which in_stall_o rises and the whole pipeline holds.
//
module atlas_tile_pixel_address_mapper #(
  parameter int unsigned TILE_SIZE       = 256,
  parameter int unsigned BORDER          = 8,
  parameter int unsigned MAX_TILES       = 256,
  parameter int unsigned MAX_TEXTURE_DIM = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  atpam_pkg::atpam_in_t          in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output atpam_pkg::atpam_out_t         out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atpam_pkg::GRID_W-1:0]  cfg_data_i
);

  import atpam_pkg::*;

  // TILE_SIZE is taken as a power of two: the tile split is a shift.
  localparam int unsigned LT     = $clog2(TILE_SIZE);
  localparam int unsigned TXW    = PIX_W - LT;
  localparam int unsigned IW     = TXW + GRID_W + 1;
  localparam int unsigned CW     = (TXW > GRID_W) ? TXW : GRID_W;
  localparam int unsigned AW     = $clog2(MAX_TILES);
  localparam int unsigned DW     = $clog2(MAX_TEXTURE_DIM + 1);
  localparam int unsigned QW     = $clog2(MAX_TEXTURE_DIM);
  localparam int unsigned EW     = (DW > DIM_W) ? DW : DIM_W;
  localparam int unsigned PRW    = LT + DW;
  localparam int unsigned DESC_W = 2 * DW + BPP_W + 1;
  localparam int unsigned LAT_R  = QW + 2;
  localparam int unsigned SYW    = QW + DW;
  localparam int unsigned SXW    = QW + BPP_W;

  // --------------------------------------------------------------------------
  // Configuration and flow control
  // --------------------------------------------------------------------------
  logic [GRID_W-1:0] grid_q;
  logic              skid_v_q;
  logic              adv;
  logic              acc;
  logic              is_map;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_valid_i) begin
      grid_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Every stage moves together; only a full skid register holds them.
  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign acc        = in_valid_i && adv;
  assign is_map     = (in_word_i.cmd == CMD_MAP);

  // --------------------------------------------------------------------------
  // Entry: tile lookup address and descriptor write
  // --------------------------------------------------------------------------
  logic [TXW-1:0]    tx0;
  logic [TXW-1:0]    ty0;
  logic [IW-1:0]     idx0;
  logic              hit0;
  logic [EW-1:0]     w_ext;
  logic [EW-1:0]     h_ext;
  logic [DW-1:0]     w_cl;
  logic [DW-1:0]     h_cl;
  logic              wr_en;
  logic [DESC_W-1:0] wr_data;

  always_comb begin
    tx0  = in_word_i.pixel_x[PIX_W-1:LT];
    ty0  = in_word_i.pixel_y[PIX_W-1:LT];
    idx0 = IW'(IW'(ty0) * IW'(grid_q)) + IW'(tx0);
    // A pixel beyond the grid, or a grid index past the table, maps to an
    // empty tile.
    hit0 = (CW'(tx0) < CW'(grid_q)) && (CW'(ty0) < CW'(grid_q)) &&
           ({1'b0, idx0} < (IW + 1)'(MAX_TILES));

    // Loaded sizes are saturated into the supported texture range.
    w_ext = EW'(in_word_i.tile_width);
    h_ext = EW'(in_word_i.tile_height);
    if (w_ext == '0) begin
      w_cl = DW'(1);
    end else if (w_ext > EW'(MAX_TEXTURE_DIM)) begin
      w_cl = DW'(MAX_TEXTURE_DIM);
    end else begin
      w_cl = DW'(w_ext);
    end
    if (h_ext == '0) begin
      h_cl = DW'(1);
    end else if (h_ext > EW'(MAX_TEXTURE_DIM)) begin
      h_cl = DW'(MAX_TEXTURE_DIM);
    end else begin
      h_cl = DW'(h_ext);
    end

    wr_en   = acc && !is_map &&
              ({1'b0, in_word_i.tile_slot} < (SLOT_W + 1)'(MAX_TILES));
    wr_data = {in_word_i.tile_present, w_cl, h_cl, in_word_i.bytes_per_pixel};
  end

  logic              rd_valid;
  logic [DESC_W-1:0] rd_data;

  atpam_tile_table #(
    .DEPTH  (MAX_TILES),
    .DATA_W (DESC_W)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (in_word_i.tile_slot[AW-1:0]),
    .wr_data_i  (wr_data),
    .rd_en_i    (adv),
    .rd_addr_i  (idx0[AW-1:0]),
    .rd_valid_o (rd_valid),
    .rd_data_o  (rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage 1: table read in flight
  // --------------------------------------------------------------------------
  logic               v1_q;
  logic [LT-1:0]      ux1_q;
  logic [LT-1:0]      uy1_q;
  logic [INDEX_W-1:0] idx1_q;
  logic               hit1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc && is_map;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux1_q  <= in_word_i.pixel_x[LT-1:0];
      uy1_q  <= in_word_i.pixel_y[LT-1:0];
      // An off-grid pixel reports tile index zero.
      idx1_q <= ((CW'(tx0) < CW'(grid_q)) && (CW'(ty0) < CW'(grid_q))) ?
                idx0[INDEX_W-1:0] : '0;
      hit1_q <= hit0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: descriptor decode and coordinate scaling products
  // --------------------------------------------------------------------------
  logic               rd_present;
  logic [DW-1:0]      rd_w;
  logic [DW-1:0]      rd_h;
  logic [BPP_W-1:0]   rd_bpp;

  assign rd_present = rd_valid && rd_data[DESC_W-1];
  assign rd_w       = rd_data[DESC_W-2 -: DW];
  assign rd_h       = rd_data[BPP_W +: DW];
  assign rd_bpp     = rd_data[BPP_W-1:0];

  logic               v2_q;
  logic               live2_q;
  logic [INDEX_W-1:0] idx2_q;
  logic [DW-1:0]      w2_q;
  logic [DW-1:0]      h2_q;
  logic [BPP_W-1:0]   bpp2_q;
  logic [PRW-1:0]     prodx2_q;
  logic [PRW-1:0]     prody2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      live2_q  <= hit1_q && rd_present;
      idx2_q   <= idx1_q;
      w2_q     <= rd_w;
      h2_q     <= rd_h;
      bpp2_q   <= rd_bpp;
      prodx2_q <= PRW'(PRW'(ux1_q) * PRW'(rd_w));
      prody2_q <= PRW'(PRW'(uy1_q) * PRW'(rd_h));
    end
  end

  // --------------------------------------------------------------------------
  // Border remap, one divider pipeline per axis
  // --------------------------------------------------------------------------
  logic [QW-1:0] sx;
  logic [QW-1:0] sy;

  atpam_remap #(
    .TILE_SIZE       (TILE_SIZE),
    .BORDER          (BORDER),
    .MAX_TEXTURE_DIM (MAX_TEXTURE_DIM)
  ) u_remap_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .prod_i  (prodx2_q),
    .size_i  (w2_q),
    .coord_o (sx)
  );

  atpam_remap #(
    .TILE_SIZE       (TILE_SIZE),
    .BORDER          (BORDER),
    .MAX_TEXTURE_DIM (MAX_TEXTURE_DIM)
  ) u_remap_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .prod_i  (prody2_q),
    .size_i  (h2_q),
    .coord_o (sy)
  );

  // Side data travels beside the remap pipelines so that it lines up with
  // the coordinates at their last stage.
  logic               sb_v_q    [LAT_R];
  logic               sb_live_q [LAT_R];
  logic [INDEX_W-1:0] sb_idx_q  [LAT_R];
  logic [DW-1:0]      sb_w_q    [LAT_R];
  logic [BPP_W-1:0]   sb_bpp_q  [LAT_R];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(LAT_R); k++) begin
        sb_v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      sb_v_q[0] <= v2_q;
      for (int k = 1; k < int'(LAT_R); k++) begin
        sb_v_q[k] <= sb_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_live_q[0] <= live2_q;
      sb_idx_q[0]  <= idx2_q;
      sb_w_q[0]    <= w2_q;
      sb_bpp_q[0]  <= bpp2_q;
      for (int k = 1; k < int'(LAT_R); k++) begin
        sb_live_q[k] <= sb_live_q[k-1];
        sb_idx_q[k]  <= sb_idx_q[k-1];
        sb_w_q[k]    <= sb_w_q[k-1];
        sb_bpp_q[k]  <= sb_bpp_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Offset: row start first, then the byte scaling and the column term
  // --------------------------------------------------------------------------
  logic               vp1_q;
  logic               livep1_q;
  logic [INDEX_W-1:0] idxp1_q;
  logic [BPP_W-1:0]   bppp1_q;
  logic [SYW-1:0]     syw_q;
  logic [SXW-1:0]     sxb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
    end else if (adv) begin
      vp1_q <= sb_v_q[LAT_R-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      livep1_q <= sb_live_q[LAT_R-1];
      idxp1_q  <= sb_idx_q[LAT_R-1];
      bppp1_q  <= sb_bpp_q[LAT_R-1];
      syw_q    <= SYW'(SYW'(sy) * SYW'(sb_w_q[LAT_R-1]));
      sxb_q    <= SXW'(SXW'(sx) * SXW'(sb_bpp_q[LAT_R-1]));
    end
  end

  logic       pv_q;
  atpam_out_t pd_q;
  atpam_out_t pd_d;

  always_comb begin
    pd_d.tile_index = idxp1_q;
    pd_d.empty_tile = !livep1_q;
    if (livep1_q) begin
      // Only the low offset bits are kept; with more than four bytes per pixel a large texture's offset can wrap.
      pd_d.source_offset     = OFFSET_W'(OFFSET_W'(syw_q) * OFFSET_W'(bppp1_q)) +
                               OFFSET_W'(sxb_q);
      pd_d.alpha_from_source = (bppp1_q == BPP_RGBA);
    end else begin
      pd_d.source_offset     = '0;
      pd_d.alpha_from_source = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv) begin
      pv_q <= vp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_q <= pd_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid
  // --------------------------------------------------------------------------
  logic       out_valid_q;
  atpam_out_t out_word_q;
  atpam_out_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= skid_v_q || pv_q;
      skid_v_q    <= 1'b0;
    end else if (pv_q && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_word_q <= skid_v_q ? skid_q : pd_q;
    end else if (!skid_v_q) begin
      skid_q <= pd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_q)
    else $error("skid holds a word while the output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(pv_q))
    else $error("pipeline moved while the skid was full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_map) |=> !v1_q)
    else $error("a load word entered the result pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.empty_tile) |->
      (out_word_o.source_offset == '0 && !out_word_o.alpha_from_source))
    else $error("empty tile result carries an offset or source alpha");

endmodule

>>> hw/rtl/atpam_tile_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atlas tile table
// Descriptor memory with one write and one registered read port, plus a
// per-entry valid bit that reset clears so unwritten slots read as absent.
// ----------------------------------------------------------------------------
module atpam_tile_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 30
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic                     rd_valid_o,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic              rd_valid_q;
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = rd_data_q;

endmodule

>>> hw/rtl/atpam_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atlas axis remap
// Scales an in-tile product to the texture axis and applies the border
// remap, with a pipelined restoring divider that retires one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module atpam_remap #(
  parameter int unsigned TILE_SIZE       = 256,
  parameter int unsigned BORDER          = 8,
  parameter int unsigned MAX_TEXTURE_DIM = 4096
) (
  input  logic                                                 clk_i,
  input  logic                                                 en_i,
  input  logic [$clog2(TILE_SIZE)+$clog2(MAX_TEXTURE_DIM+1)-1:0] prod_i,
  input  logic [$clog2(MAX_TEXTURE_DIM+1)-1:0]                 size_i,
  output logic [$clog2(MAX_TEXTURE_DIM)-1:0]                   coord_o
);

  localparam int unsigned LT = $clog2(TILE_SIZE);
  localparam int unsigned DW = $clog2(MAX_TEXTURE_DIM + 1);
  localparam int unsigned QW = $clog2(MAX_TEXTURE_DIM);
  localparam int unsigned SW = DW + 1;
  localparam int unsigned PW = DW + SW;
  localparam int unsigned RW = DW + QW;

  logic [DW-1:0] t;
  logic          below;
  logic          above;
  logic [DW-1:0] diff;
  logic [SW-1:0] span;
  logic [RW-1:0] dividend;

  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] sz_q  [QW+1];
  logic          bel_q [QW+1];
  logic          abv_q [QW+1];
  logic [QW-1:0] coord_q;

  logic [RW-1:0] dsh   [QW];
  logic [RW-1:0] rem_n [QW];
  logic [QW-1:0] quo_n [QW];

  // The texture coordinate is the scaled product with the tile fraction
  // dropped. Only the middle band needs the divide.
  always_comb begin
    t        = prod_i[LT +: DW];
    below    = SW'(t) < SW'(BORDER);
    above    = (SW'(t) + SW'(BORDER)) > SW'(size_i);
    diff     = t - DW'(BORDER);
    span     = SW'(size_i) + SW'(2 * BORDER);
    dividend = RW'(PW'(diff) * PW'(span));
  end

  always_comb begin
    for (int k = 0; k < int'(QW); k++) begin
      dsh[k] = RW'(sz_q[k]) << (int'(QW) - 1 - k);
      if (rem_q[k] >= dsh[k]) begin
        rem_n[k] = rem_q[k] - dsh[k];
        quo_n[k] = quo_q[k] | (QW'(1) << (int'(QW) - 1 - k));
      end else begin
        rem_n[k] = rem_q[k];
        quo_n[k] = quo_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= dividend;
      quo_q[0] <= '0;
      sz_q[0]  <= size_i;
      bel_q[0] <= below;
      abv_q[0] <= above;
      for (int k = 0; k < int'(QW); k++) begin
        if (k < int'(QW) - 1) begin
          rem_q[k+1] <= rem_n[k];
        end
        quo_q[k+1] <= quo_n[k];
        sz_q[k+1]  <= sz_q[k];
        bel_q[k+1] <= bel_q[k];
        abv_q[k+1] <= abv_q[k];
      end
      if (bel_q[QW]) begin
        coord_q <= '0;
      end else if (abv_q[QW]) begin
        coord_q <= QW'(sz_q[QW] - DW'(1));
      end else begin
        coord_q <= quo_q[QW];
      end
    end
  end

  assign coord_o = coord_q;

endmodule
